// ===== rtl/rwtm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwtm_pkg
// Shared widths, defaults, register indexes and types of the wall texel mapper.
// ----------------------------------------------------------------------------
package rwtm_pkg;

	localparam int GRID_SCALE_DEF  = 64;
	localparam int SCREEN_ROWS_DEF = 1024;

	localparam int COL_W     = 11;
	localparam int ROW_W     = 10;
	localparam int SPAN_W    = 16;
	localparam int HIT_W     = 16;
	localparam int TEX_DIM_W = 11;
	localparam int FACE_W    = 2;
	localparam int TEXEL_W   = 20;

	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 48;
	localparam int CFG_IDX_W = 1;

	localparam logic [TEX_DIM_W-1:0] TEX_WIDTH_RST  = TEX_DIM_W'(64);
	localparam logic [TEX_DIM_W-1:0] TEX_HEIGHT_RST = TEX_DIM_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXTURE_WIDTH  = 1'b0,
		REG_TEXTURE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [FACE_W-1:0] {
		FACE_NORTH = 2'd0,
		FACE_SOUTH = 2'd1,
		FACE_EAST  = 2'd2,
		FACE_WEST  = 2'd3
	} face_t;

	// per-pixel fields that ride along the pipeline
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             draw;
		face_t            face;
	} pix_t;

	// result entry, last field in the low bits
	typedef struct packed {
		logic [TEXEL_W-1:0] texel;
		face_t              face;
		logic               draw;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
	} res_t;

endpackage

// ===== rtl/rwtm_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rwtm_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a payload
// that travels alongside. The quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module rwtm_div_pipe
	import rwtm_pkg::*;
#(
	parameter int DEN_W = SPAN_W,
	parameter int QUO_W = TEX_DIM_W,
	parameter int PAY_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [DEN_W+QUO_W-1:0] num,
	input  logic [DEN_W-1:0]       den,
	input  logic [PAY_W-1:0]       pay_in,
	output logic                   out_valid,
	output logic [QUO_W-1:0]       quo,
	output logic [PAY_W-1:0]       pay_out
);

	localparam int NUM_W = DEN_W + QUO_W;

	// stage registers
	logic [NUM_W-1:0] rem_s [QUO_W-1];
	logic [DEN_W-1:0] den_s [QUO_W-1];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [PAY_W-1:0] pay_s [QUO_W];
	logic             v_s   [QUO_W];

	// stage inputs and step results
	logic [NUM_W-1:0] r_in [QUO_W];
	logic [DEN_W-1:0] d_in [QUO_W];
	logic [QUO_W-1:0] q_in [QUO_W];
	logic [PAY_W-1:0] p_in [QUO_W];
	logic             v_in [QUO_W];
	logic [NUM_W-1:0] d_sh [QUO_W];
	logic [QUO_W-1:0] q_nx [QUO_W];
	logic             fits [QUO_W];

	always_comb begin
		r_in[0] = num;
		d_in[0] = den;
		q_in[0] = '0;
		p_in[0] = pay_in;
		v_in[0] = in_valid;
		for (int k = 1; k < QUO_W; k++) begin
			r_in[k] = rem_s[k-1];
			d_in[k] = den_s[k-1];
			q_in[k] = quo_s[k-1];
			p_in[k] = pay_s[k-1];
			v_in[k] = v_s[k-1];
		end
		for (int k = 0; k < QUO_W; k++) begin
			d_sh[k] = NUM_W'(d_in[k]) << (QUO_W - 1 - k);
			fits[k] = r_in[k] >= d_sh[k];
			q_nx[k] = q_in[k];
			q_nx[k][QUO_W-1-k] = fits[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_W; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < QUO_W; k++) v_s[k] <= v_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				quo_s[k] <= q_nx[k];
				pay_s[k] <= p_in[k];
			end
			for (int k = 0; k < QUO_W - 1; k++) begin
				rem_s[k] <= fits[k] ? r_in[k] - d_sh[k] : r_in[k];
				den_s[k] <= d_in[k];
			end
		end
	end

	assign out_valid = v_s[QUO_W-1];
	assign quo       = quo_s[QUO_W-1];
	assign pay_out   = pay_s[QUO_W-1];

endmodule

// ===== rtl/raycast_wall_texel_mapper.sv =====
// ----------------------------------------------------------------------------
// raycast_wall_texel_mapper
// Per-pixel wall span test, face pick and texel index for a raycast column.
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       s_tdata: pixel request
// m_*      out  m_tvalid / m_tready       m_tdata: pixel result
// cfg_*    in   cfg_we                    cfg_idx, cfg_wdata: texture size
//
// One request per clock while s_tready is high. From s_ to m_ a request passes five front
// stages, the eleven-stage texture-y divider (one quotient bit per stage),
// four back stages and the two-entry output buffer.
// Reset clears all valid bits and the output buffer; texture size is 64x64.
// A full output buffer holds the whole pipeline; s_tready is low only then.
// ----------------------------------------------------------------------------
module raycast_wall_texel_mapper
	import rwtm_pkg::*;
#(
	parameter int GRID_SCALE  = GRID_SCALE_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// column, row, span_top, span_bottom, hit_x, hit_y, horizontal_hit,
	// ray_points_down, ray_points_right
	input  logic [S_DATA_W-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_column, out_row, draw, face, texel_index, zero pad
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [TEX_DIM_W-1:0] cfg_wdata
);

	localparam int M_W   = $clog2(GRID_SCALE);      // coord mod scale
	localparam int R_W   = M_W + 1;                 // remainder before fold
	localparam int P_W   = M_W + TEX_DIM_W;         // (coord mod scale) * width
	localparam int NUM_W = SPAN_W + TEX_DIM_W;
	localparam int PAY_W = $bits(pix_t) + P_W;
	localparam longint unsigned RECIP1 = (64'd1 << HIT_W) / GRID_SCALE;
	localparam longint unsigned RECIP2 = (64'd1 << P_W) / GRID_SCALE;

	logic [TEX_DIM_W-1:0] tex_width_q, tex_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= TEX_WIDTH_RST;
			tex_height_q <= TEX_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TEXTURE_WIDTH:  tex_width_q  <= cfg_wdata;
				REG_TEXTURE_HEIGHT: tex_height_q <= cfg_wdata;
			endcase
		end
	end

	logic en;
	logic [1:0] cnt_q;
	assign en       = cnt_q != 2'd2;
	assign s_tready = en;

	// ---- request unpack ----
	logic [COL_W-1:0]  in_col;
	logic [ROW_W-1:0]  in_row;
	logic [HIT_W-1:0]  in_hx, in_hy, in_coord;
	logic              in_horiz, in_down, in_right;
	logic signed [SPAN_W:0] row_x, top_x, bot_x, offs_x, span_x;
	pix_t in_pix;

	always_comb begin
		in_col   = s_tdata[10:0];
		in_row   = s_tdata[20:11];
		top_x    = {s_tdata[36], s_tdata[36:21]};
		bot_x    = {s_tdata[52], s_tdata[52:37]};
		in_hx    = s_tdata[68:53];
		in_hy    = s_tdata[84:69];
		in_horiz = s_tdata[85];
		in_down  = s_tdata[86];
		in_right = s_tdata[87];
		row_x    = $signed((SPAN_W+1)'(in_row));
		offs_x   = row_x - top_x;
		span_x   = bot_x - top_x;
		in_coord = in_horiz ? in_hx : in_hy;

		in_pix.col  = in_col;
		in_pix.row  = in_row;
		// row is never negative, so the top clamp at zero drops out
		in_pix.draw = (row_x >= top_x) && (row_x < bot_x)
			&& ((ROW_W+1)'(in_row) < (ROW_W+1)'(SCREEN_ROWS));
		if (in_horiz) in_pix.face = in_down ? FACE_SOUTH : FACE_NORTH;
		else          in_pix.face = in_right ? FACE_EAST : FACE_WEST;
	end

	// ---- front stages ----
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	pix_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	logic [HIT_W-1:0]    coord_s1, coord_s2;
	logic [2*HIT_W-1:0]  qest_s1;
	logic [SPAN_W-1:0]   offs_s1, span_s1, span_s2, span_s3, span_s4, span_s5;
	logic [HIT_W-1:0]    pm_s2;
	logic [NUM_W-1:0]    num_s2, num_s3, num_s4, num_s5;
	logic [R_W-1:0]      rem_s3;
	logic [M_W-1:0]      m_s4;
	logic [P_W-1:0]      p_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1   <= in_pix;
			coord_s1 <= in_coord;
			// floor(coord * floor(2^16/scale) / 2^16) is the quotient or one less
			qest_s1  <= (2*HIT_W)'(in_coord) * (2*HIT_W)'(RECIP1);
			offs_s1  <= offs_x[SPAN_W-1:0];
			span_s1  <= span_x[SPAN_W-1:0];

			pix_s2   <= pix_s1;
			coord_s2 <= coord_s1;
			pm_s2    <= HIT_W'((2*HIT_W)'(qest_s1[2*HIT_W-1:HIT_W])
				* (2*HIT_W)'(GRID_SCALE));
			num_s2   <= NUM_W'(offs_s1) * NUM_W'(tex_height_q);
			span_s2  <= span_s1;

			pix_s3   <= pix_s2;
			rem_s3   <= R_W'(coord_s2 - pm_s2);
			num_s3   <= num_s2;
			span_s3  <= span_s2;

			pix_s4   <= pix_s3;
			m_s4     <= (rem_s3 >= R_W'(GRID_SCALE)) ? M_W'(rem_s3 - R_W'(GRID_SCALE))
				: M_W'(rem_s3);
			num_s4   <= num_s3;
			span_s4  <= span_s3;

			pix_s5   <= pix_s4;
			p_s5     <= P_W'(m_s4) * P_W'(tex_width_q);
			num_s5   <= num_s4;
			span_s5  <= span_s4;
		end
	end

	// ---- texture y: (row - top) * height / span ----
	logic                 v_s16;
	logic [TEX_DIM_W-1:0] ty_s16;
	logic [PAY_W-1:0]     pay_s16;

	rwtm_div_pipe #(
		.DEN_W (SPAN_W),
		.QUO_W (TEX_DIM_W),
		.PAY_W (PAY_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num       (num_s5),
		.den       (span_s5),
		.pay_in    ({pix_s5, p_s5}),
		.out_valid (v_s16),
		.quo       (ty_s16),
		.pay_out   (pay_s16)
	);

	// ---- back stages: texture x = p / scale, then the index ----
	logic v_s17, v_s18, v_s19, v_s20;
	pix_t pix_s16, pix_s17, pix_s18, pix_s19;
	logic [P_W-1:0]       p_s16, p_s17, p_s18, qg_s18;
	logic [TEX_DIM_W-1:0] ty_s17, qx_c, qx_s18, qx_s19;
	logic [2*P_W-1:0]     pq_s17;
	logic [TEXEL_W-1:0]   tyw_s18, tyw_s19;
	logic [R_W-1:0]       rx_s19;
	res_t                 res_s20;

	assign {pix_s16, p_s16} = pay_s16;
	assign qx_c = TEX_DIM_W'(pq_s17 >> P_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
		end else if (en) begin
			v_s17 <= v_s16;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s17 <= pix_s16;
			p_s17   <= p_s16;
			ty_s17  <= ty_s16;
			pq_s17  <= (2*P_W)'(p_s16) * (2*P_W)'(RECIP2);

			pix_s18 <= pix_s17;
			p_s18   <= p_s17;
			qx_s18  <= qx_c;
			qg_s18  <= P_W'(P_W'(qx_c) * P_W'(GRID_SCALE));
			tyw_s18 <= TEXEL_W'((2*TEX_DIM_W)'(ty_s17) * (2*TEX_DIM_W)'(tex_width_q));

			pix_s19 <= pix_s18;
			qx_s19  <= qx_s18;
			rx_s19  <= R_W'(p_s18 - qg_s18);
			tyw_s19 <= tyw_s18;

			res_s20.col  <= pix_s19.col;
			res_s20.row  <= pix_s19.row;
			res_s20.draw <= pix_s19.draw;
			res_s20.face <= pix_s19.face;
			// quotient estimate may be one short; remainder fixes it
			res_s20.texel <= pix_s19.draw ? TEXEL_W'(tyw_s19 + TEXEL_W'(qx_s19)
				+ TEXEL_W'(rx_s19 >= R_W'(GRID_SCALE))) : '0;
		end
	end

	// ---- two-entry output buffer ----
	res_t buf_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic push, pop;

	assign push     = en && v_s20;
	assign m_tvalid = cnt_q != 2'd0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = M_DATA_W'(buf_q[rd_ptr_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= res_s20;
	end

	// ---- checks ----
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("output buffer lost a push");

	a_ty_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s17 && pix_s17.draw) |-> (ty_s17 < tex_height_q) || (tex_height_q == '0))
		else $error("texture y out of range");

	a_undrawn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[21]) |-> m_tdata[43:24] == '0)
		else $error("texel index set on an undrawn pixel");

endmodule
